// ----- rtl/core/pov_clock_face_column_top_macros.svh -----
// assertion macros used by the checker file
`ifndef POV_CLOCK_FACE_COLUMN_TOP_MACROS_SVH
`define POV_CLOCK_FACE_COLUMN_TOP_MACROS_SVH

// same-cycle implication, held off while reset is low
`define PCFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcfc assertion failed");

// next-cycle implication, held off while reset is low
`define PCFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcfc assertion failed");

`endif

// ----- rtl/core/pcfc_pkg.sv -----
// constants, types and face tables of the clock face column generator
package pcfc_pkg;

    localparam int unsigned SLOTS_PER_TURN = 180;

    localparam logic [7:0] LED_OFF   = 8'hff;
    localparam logic [7:0] LED_ON    = 8'h00;
    localparam logic [7:0] TICK_DOT  = 8'hfe;
    localparam logic [7:0] TICK_MARK = 8'hfc;
    localparam logic [7:0] SEC_MASK  = 8'h07;
    localparam logic [7:0] MIN_NB    = 8'h01;
    localparam logic [7:0] HOUR_MASK = 8'h0f;
    localparam logic [7:0] HOUR_NB1  = 8'h1f;
    localparam logic [7:0] HOUR_NB2  = 8'h3f;

    typedef struct packed {
        logic [7:0] col_d;
        logic [7:0] col_c;
        logic [7:0] col_b;
        logic [7:0] col_a;
    } t_column;

    localparam t_column COLUMN_DARK = '{col_d: LED_OFF, col_c: LED_OFF,
                                       col_b: LED_OFF, col_a: LED_OFF};

    // numeral face: 12, 3, 6, 9 bitmaps plus the hour dots
    function automatic logic [7:0] numeral_face(input logic [7:0] ang);
        logic [7:0] pix;
        unique case (ang)
            8'd1:                                pix = 8'hcd;
            8'd2, 8'd3, 8'd4:                    pix = 8'hb6;
            8'd5:                                pix = 8'hb9;
            8'd179:                              pix = 8'h80;
            8'd42, 8'd45, 8'd48:                 pix = 8'hf1;
            8'd43, 8'd47:                        pix = 8'hee;
            8'd44, 8'd46:                        pix = 8'hfe;
            8'd88:                               pix = 8'hd9;
            8'd89, 8'd90, 8'd91:                 pix = 8'hb6;
            8'd92:                               pix = 8'hc1;
            8'd132, 8'd138:                      pix = 8'hf1;
            8'd133, 8'd136, 8'd137:              pix = 8'hee;
            8'd134:                              pix = 8'hef;
            8'd135:                              pix = 8'he1;
            8'd15, 8'd30, 8'd60, 8'd75,
            8'd105, 8'd120, 8'd150, 8'd165:      pix = TICK_MARK;
            default:                             pix = LED_OFF;
        endcase
        return pix;
    endfunction

endpackage

// ----- rtl/core/pcfc_if.sv -----
// valid/ready channels of the clock face column generator

interface pcfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] slot_count;
    logic [3:0] hour_value;
    logic [5:0] minute_value;
    logic [5:0] second_value;

    modport source (output valid, slot_count, hour_value, minute_value, second_value,
                    input ready);
    modport sink   (input valid, slot_count, hour_value, minute_value, second_value,
                    output ready);
endinterface

interface pcfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] column_a;
    logic [7:0] column_b;
    logic [7:0] column_c;
    logic [7:0] column_d;
    logic       angle_in_range;

    modport source (output valid, column_a, column_b, column_c, column_d, angle_in_range,
                    input ready);
    modport sink   (input valid, column_a, column_b, column_c, column_d, angle_in_range,
                    output ready);
endinterface

interface pcfc_cfg_if;
    logic valid;
    logic ready;
    logic face_mode;

    modport source (output valid, face_mode, input ready);
    modport sink   (input valid, face_mode, output ready);
endinterface

// ----- rtl/core/pov_clock_face_column_top.sv -----
// Clock face column generator: one LED column per rotor slot.
// Each item passes through the input register, then the result register, where it
// waits until the result side takes it; a stall can hold it in either register.
// Throughput: one item per cycle while the result side keeps ready high; the
// input register and the result register each hold one item.
// Reset clears both valid flags, sets face_mode to 0 and the held column to all ones (dark).
module pov_clock_face_column_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pcfc_in_if.sink        i_item,
    pcfc_cfg_if.sink       i_cfg,
    pcfc_out_if.source     o_result
);

    logic        r_s1_valid;
    logic [7:0]  r_slot;
    logic [3:0]  r_hour;
    logic [5:0]  r_min;
    logic [5:0]  r_sec;

    logic        r_face_mode;
    logic        r_out_valid;
    logic        r_out_inr;
    pcfc_pkg::t_column r_held;

    logic        s1_advance;
    logic        in_take;
    logic        n_inr;
    pcfc_pkg::t_column n_col;

    assign s1_advance     = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_s1_valid || !r_out_valid || o_result.ready;
    assign in_take        = i_item.valid && i_item.ready;
    assign i_cfg.ready    = 1'b1;

    assign o_result.valid          = r_out_valid;
    assign o_result.column_a       = r_held.col_a;
    assign o_result.column_b       = r_held.col_b;
    assign o_result.column_c       = r_held.col_c;
    assign o_result.column_d       = r_held.col_d;
    assign o_result.angle_in_range = r_out_inr;

    // column computation from the registered item
    always_comb begin
        logic [7:0]  ang;
        logic [16:0] prod3;
        logic [7:0]  q3;
        logic [9:0]  mul3;
        logic [16:0] prod15;
        logic [4:0]  q15;
        logic [9:0]  mul15;
        logic [11:0] prod12;
        logic [2:0]  mq;
        logic [4:0]  m3;
        logic [9:0]  hp;
        logic [9:0]  ang1;
        logic [9:0]  ang2;
        logic [9:0]  angw;
        logic [9:0]  mn3;
        logic [9:0]  sc3;
        logic        div3;
        logic        div15;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;

        ang    = r_slot - 8'd1;
        angw   = 10'(ang);
        ang1   = angw + 10'd1;
        ang2   = angw + 10'd2;
        // divide by 3 and by 15 through reciprocal multiplies, exact for 8-bit values
        prod3  = 17'(ang) * 17'd171;
        q3     = 8'(prod3 >> 9);
        mul3   = 10'(q3) * 10'd3;
        div3   = (mul3 == angw);
        prod15 = 17'(ang) * 17'd137;
        q15    = 5'(prod15 >> 11);
        mul15  = 10'(q15) * 10'd15;
        div15  = (mul15 == angw);
        // minute / 12, exact for every 6-bit minute value
        prod12 = 12'(r_min) * 12'd43;
        mq     = 3'(prod12 >> 9);
        m3     = 5'(mq) * 5'd3;
        hp     = 10'(r_hour) * 10'd15 + 10'(m3);
        mn3    = 10'(r_min) * 10'd3;
        sc3    = 10'(r_sec) * 10'd3;

        n_inr  = (angw <= 10'(pcfc_pkg::SLOTS_PER_TURN));

        b = pcfc_pkg::LED_OFF;
        c = pcfc_pkg::LED_OFF;
        d = pcfc_pkg::LED_OFF;
        if (r_face_mode) begin
            a = pcfc_pkg::numeral_face(ang);
        end else begin
            a = div3 ? pcfc_pkg::TICK_DOT : pcfc_pkg::LED_OFF;
            if (div15 || ang == 8'd179 || ang == 8'd1) begin
                a = a & pcfc_pkg::TICK_MARK;
            end
        end

        if (div3) begin
            if (angw == sc3 || ang == 8'd179) begin
                a = a & pcfc_pkg::SEC_MASK;
                b = pcfc_pkg::LED_ON;
                c = pcfc_pkg::LED_ON;
                d = pcfc_pkg::LED_ON;
            end
            if (angw == mn3) begin
                b = pcfc_pkg::LED_ON;
                c = pcfc_pkg::LED_ON;
                d = pcfc_pkg::LED_ON;
            end
            if (angw == hp) begin
                b = b & pcfc_pkg::HOUR_MASK;
                c = pcfc_pkg::LED_ON;
                d = pcfc_pkg::LED_ON;
            end
        end else begin
            if (ang == 8'd1 || ang == 8'd179) begin
                a = a & pcfc_pkg::TICK_MARK;
                c = pcfc_pkg::LED_OFF;
                d = pcfc_pkg::LED_OFF;
            end
            // hand neighbors, compared without going below zero
            if (ang1 == mn3 || angw == mn3 + 10'd1) begin
                b = b & pcfc_pkg::MIN_NB;
                c = pcfc_pkg::LED_ON;
                d = pcfc_pkg::LED_ON;
            end
            if (ang1 == hp || angw == hp + 10'd1) begin
                b = b & pcfc_pkg::HOUR_NB1;
                c = pcfc_pkg::LED_ON;
                d = pcfc_pkg::LED_ON;
            end
            if (ang2 == hp || angw == hp + 10'd2) begin
                b = b & pcfc_pkg::HOUR_NB2;
                c = pcfc_pkg::LED_ON;
                d = pcfc_pkg::LED_ON;
            end
            // minute hand at twelve also marks both sides of the seam
            if (r_min == 6'd0) begin
                if (ang1 == 10'(pcfc_pkg::SLOTS_PER_TURN) || ang == 8'd1) begin
                    b = b & pcfc_pkg::MIN_NB;
                    c = pcfc_pkg::LED_ON;
                    d = pcfc_pkg::LED_ON;
                end
            end
            // hour hand near twelve wraps to the end of the turn
            if (r_hour == 4'd0) begin
                if (ang1 == 10'(pcfc_pkg::SLOTS_PER_TURN) + 10'(m3)
                        || angw == hp + 10'd1) begin
                    b = b & pcfc_pkg::HOUR_NB1;
                    c = pcfc_pkg::LED_ON;
                    d = pcfc_pkg::LED_ON;
                end
                if (ang2 == 10'(pcfc_pkg::SLOTS_PER_TURN) + 10'(m3)
                        || angw == hp + 10'd2) begin
                    b = b & pcfc_pkg::HOUR_NB2;
                    c = pcfc_pkg::LED_ON;
                    d = pcfc_pkg::LED_ON;
                end
            end
        end

        n_col = '{col_d: d, col_c: c, col_b: b, col_a: a};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_face_mode <= 1'b0;
            r_held      <= pcfc_pkg::COLUMN_DARK;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_face_mode <= i_cfg.face_mode;
            end
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
                r_out_inr   <= n_inr;
                // out-of-range angles resend the held column
                if (n_inr) begin
                    r_held <= n_col;
                end
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_slot <= i_item.slot_count;
            r_hour <= i_item.hour_value;
            r_min  <= i_item.minute_value;
            r_sec  <= i_item.second_value;
        end
    end

endmodule

// ----- rtl/core/pcfc_checker.sv -----
// port-level checks of the clock face column generator, bound to the top level
`include "pov_clock_face_column_top_macros.svh"

module pcfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_column_a,
    input logic [7:0] i_column_b,
    input logic [7:0] i_column_c,
    input logic [7:0] i_column_d,
    input logic       i_angle_in_range
);

    logic [1:0]  r_pending;
    logic [31:0] r_last;
    logic        in_xfer;
    logic        out_xfer;
    logic        out_stall;
    logic [31:0] cur_col;
    logic [32:0] out_word;

    assign in_xfer   = i_in_valid && i_in_ready;
    assign out_xfer  = i_out_valid && i_out_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign cur_col   = {i_column_d, i_column_c, i_column_b, i_column_a};
    assign out_word  = {cur_col, i_angle_in_range};

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_last    <= 32'hffff_ffff;
        end else begin
            if (in_xfer && !out_xfer) begin
                r_pending <= r_pending + 2'd1;
            end else if (out_xfer && !in_xfer) begin
                r_pending <= r_pending - 2'd1;
            end
            if (out_xfer) begin
                r_last <= cur_col;
            end
        end
    end

    `PCFC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_word))
    `PCFC_ASSERT_NOW(a_resend_held, i_clk, i_rst_n, out_xfer && !i_angle_in_range, cur_col == r_last)
    `PCFC_ASSERT_NOW(a_no_phantom, i_clk, i_rst_n, i_out_valid, r_pending != 2'd0)
    `PCFC_ASSERT_NOW(a_depth_bound, i_clk, i_rst_n, 1'b1, r_pending != 2'd3)

endmodule

bind pov_clock_face_column_top pcfc_checker u_pcfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_item.valid),
    .i_in_ready       (i_item.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_column_a       (o_result.column_a),
    .i_column_b       (o_result.column_b),
    .i_column_c       (o_result.column_c),
    .i_column_d       (o_result.column_d),
    .i_angle_in_range (o_result.angle_in_range)
);

// ----- verif/pov_clock_face_column_top_tb.sv -----
// testbench of the clock face column generator: directed and random slots against a predictor
`timescale 1ns / 100ps

module pov_clock_face_column_top_tb;

    localparam logic FACE_TICKS     = 1'b0;
    localparam logic FACE_NUMERALS  = 1'b1;
    localparam int   RAND_PER_PHASE = 180;
    localparam int   TURN           = int'(pcfc_pkg::SLOTS_PER_TURN);

    typedef struct packed {
        logic [7:0] slot;
        logic [3:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_slot_item;

    typedef struct packed {
        pcfc_pkg::t_column col;
        logic              in_range;
    } t_expect;

    logic i_clk;
    logic i_rst_n;

    pcfc_in_if  in_ch ();
    pcfc_cfg_if cfg_ch ();
    pcfc_out_if res_ch ();

    pov_clock_face_column_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    t_slot_item        pending_slots[$];
    t_expect           columns_due[$];
    pcfc_pkg::t_column held_col;
    logic              face_mode_now;
    int                mismatches;
    int                burst_left;
    int                gap_left;
    int                stall_left;
    int                ready_mode;
    int                ready_cyc;
    t_slot_item        next_slot;
    t_expect           want_col;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                   input logic [7:0] got_v);
        $display("%0t mismatch on %s: expected %02h got %02h", $time, what, exp_v, got_v);
        mismatches++;
    endtask

    // numeral face bitmaps: 12, 3, 6, 9 and the hour dots
    function automatic logic [7:0] numeral_pixels(input int ang);
        logic [7:0] pix;
        case (ang)
            1:                                 pix = 8'hcd;
            2, 3, 4:                           pix = 8'hb6;
            5:                                 pix = 8'hb9;
            179:                               pix = 8'h80;
            42, 45, 48:                        pix = 8'hf1;
            43, 47:                            pix = 8'hee;
            44, 46:                            pix = 8'hfe;
            88:                                pix = 8'hd9;
            89, 90, 91:                        pix = 8'hb6;
            92:                                pix = 8'hc1;
            132, 138:                          pix = 8'hf1;
            133, 136, 137:                     pix = 8'hee;
            134:                               pix = 8'hef;
            135:                               pix = 8'he1;
            15, 30, 60, 75, 105, 120, 150, 165: pix = pcfc_pkg::TICK_MARK;
            default:                           pix = pcfc_pkg::LED_OFF;
        endcase
        return pix;
    endfunction

    // column for one slot; updates the held column when the angle is on the dial
    function automatic t_expect predict_column(input t_slot_item it);
        t_expect    res;
        logic [7:0] ang8;
        int         ang, hr, mn, sc, m3, hp;
        logic [7:0] a, b, c, d;
        logic       hour_nb1, hour_nb2;
        ang8 = it.slot - 8'd1;
        ang = int'(ang8);
        hr = int'(it.hour);
        mn = int'(it.minute);
        sc = int'(it.second);
        res.in_range = 1'b0;
        if (ang <= TURN) begin
            m3 = (mn / 12) * 3;
            hp = 15 * hr + m3;
            a = pcfc_pkg::LED_OFF;
            b = pcfc_pkg::LED_OFF;
            c = pcfc_pkg::LED_OFF;
            d = pcfc_pkg::LED_OFF;
            res.in_range = 1'b1;
            if (face_mode_now == FACE_NUMERALS) begin
                a = numeral_pixels(ang);
            end else begin
                if (ang % 3 == 0) a = pcfc_pkg::TICK_DOT;
                if (ang % 15 == 0 || ang == 179 || ang == 1) a &= pcfc_pkg::TICK_MARK;
            end
            if (ang % 3 == 0) begin
                if (ang == 3 * sc) begin
                    a &= pcfc_pkg::SEC_MASK;
                    b = pcfc_pkg::LED_ON;
                    c = pcfc_pkg::LED_ON;
                    d = pcfc_pkg::LED_ON;
                end
                if (ang == 3 * mn) begin
                    b = pcfc_pkg::LED_ON;
                    c = pcfc_pkg::LED_ON;
                    d = pcfc_pkg::LED_ON;
                end
                if (ang == hp) begin
                    b &= pcfc_pkg::HOUR_MASK;
                    c = pcfc_pkg::LED_ON;
                    d = pcfc_pkg::LED_ON;
                end
            end else begin
                if (ang == 1 || ang == 179) a &= pcfc_pkg::TICK_MARK;
                // minute zero also lights the slots either side of twelve
                if (ang == 3 * mn - 1 || ang == 3 * mn + 1 ||
                    (mn == 0 && (ang == TURN - 1 || ang == 1))) begin
                    b &= pcfc_pkg::MIN_NB;
                    c = pcfc_pkg::LED_ON;
                    d = pcfc_pkg::LED_ON;
                end
                hour_nb1 = (ang == hp - 1 || ang == hp + 1) ||
                           (hr == 0 && ang == TURN + m3 - 1);
                hour_nb2 = (ang == hp - 2 || ang == hp + 2) ||
                           (hr == 0 && ang == TURN + m3 - 2);
                if (hour_nb1) begin
                    b &= pcfc_pkg::HOUR_NB1;
                    c = pcfc_pkg::LED_ON;
                    d = pcfc_pkg::LED_ON;
                end
                if (hour_nb2) begin
                    b &= pcfc_pkg::HOUR_NB2;
                    c = pcfc_pkg::LED_ON;
                    d = pcfc_pkg::LED_ON;
                end
            end
            held_col = '{col_d: d, col_c: c, col_b: b, col_a: a};
        end
        res.col = held_col;
        return res;
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid)
                columns_due.push_back(predict_column(t_slot_item'({in_ch.slot_count,
                    in_ch.hour_value, in_ch.minute_value, in_ch.second_value})));
            if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                gap_left--;
            end else if (pending_slots.size() > 0) begin
                next_slot = pending_slots.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.slot_count <= next_slot.slot;
                in_ch.hour_value <= next_slot.hour;
                in_ch.minute_value <= next_slot.minute;
                in_ch.second_value <= next_slot.second;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern changes every so often
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            ready_cyc = 0;
            ready_mode = 0;
            stall_left = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (columns_due.size() == 0) begin
                    report_mismatch("unexpected transfer, column_a", 8'h00, res_ch.column_a);
                end else begin
                    want_col = columns_due.pop_front();
                    if (res_ch.column_a !== want_col.col.col_a)
                        report_mismatch("column_a", want_col.col.col_a, res_ch.column_a);
                    if (res_ch.column_b !== want_col.col.col_b)
                        report_mismatch("column_b", want_col.col.col_b, res_ch.column_b);
                    if (res_ch.column_c !== want_col.col.col_c)
                        report_mismatch("column_c", want_col.col.col_c, res_ch.column_c);
                    if (res_ch.column_d !== want_col.col.col_d)
                        report_mismatch("column_d", want_col.col.col_d, res_ch.column_d);
                    if (res_ch.angle_in_range !== want_col.in_range)
                        report_mismatch("angle_in_range", {7'd0, want_col.in_range},
                                        {7'd0, res_ch.angle_in_range});
                end
            end
            ready_cyc++;
            if (ready_cyc % 97 == 0) ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= (ready_cyc % 3 != 0);
                2: res_ch.ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        res_ch.ready <= 1'b0;
                    end else begin
                        stall_left = $urandom_range(0, 12);
                        res_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic add_slot(input int slot, input int hr, input int mn, input int sc);
        pending_slots.push_back('{slot: 8'(slot), hour: 4'(hr), minute: 6'(mn),
                                  second: 6'(sc)});
    endtask

    // half of the angles near the hands, the numerals and the wrap at twelve, the rest random or off the dial
    task automatic add_random_slot();
        t_slot_item it;
        int         ang, hp;
        it.hour = ($urandom_range(0, 11) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
        it.minute = ($urandom_range(0, 11) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
        it.second = ($urandom_range(0, 11) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
        if ($urandom_range(0, 5) == 0) it.hour = 4'd0;
        if ($urandom_range(0, 7) == 0) it.minute = 6'd0;
        hp = 15 * int'(it.hour) + (int'(it.minute) / 12) * 3;
        case ($urandom_range(0, 9))
            4: ang = 3 * int'(it.second) + int'($urandom_range(0, 2)) - 1;
            5: ang = 3 * int'(it.minute) + int'($urandom_range(0, 2)) - 1;
            6: ang = hp + int'($urandom_range(0, 4)) - 2;
            7: begin
                case ($urandom_range(0, 3))
                    0: ang = 1;
                    1: ang = 42;
                    2: ang = 88;
                    default: ang = 132;
                endcase
                ang += int'($urandom_range(0, 6));
            end
            8: ang = int'($urandom_range(175, 181));
            9: ang = int'($urandom_range(181, 255));
            default: ang = int'($urandom_range(0, 255));
        endcase
        it.slot = 8'(ang + 1);
        pending_slots.push_back(it);
    endtask

    task automatic add_directed_slots();
        add_slot(0, 3, 20, 10);      // angle wraps to 255, held column resent
        add_slot(1, 0, 0, 0);        // all hands at twelve
        add_slot(2, 0, 0, 0);        // angle 1 with minute zero wrap
        add_slot(3, 0, 0, 0);
        add_slot(180, 0, 0, 0);      // last numeral slot, minute zero wrap
        add_slot(179, 0, 0, 0);      // hour zero wrap slots
        add_slot(178, 0, 0, 0);
        add_slot(181, 5, 30, 45);    // last angle on the dial
        add_slot(182, 5, 30, 45);
        add_slot(255, 11, 59, 59);
        add_slot(136, 11, 59, 59);
        add_slot(178, 11, 59, 59);   // hour and minute hands together
        add_slot(177, 11, 59, 59);
        add_slot(180, 11, 59, 59);
        add_slot(46, 4, 15, 20);
        add_slot(45, 4, 15, 20);
        add_slot(47, 4, 15, 20);
        add_slot(61, 4, 15, 20);
        add_slot(62, 4, 15, 20);
        add_slot(64, 4, 15, 20);
        add_slot(66, 4, 15, 20);
        add_slot(16, 15, 63, 63);    // out of range time values
        add_slot(91, 7, 36, 30);
        add_slot(134, 9, 45, 44);
    endtask

    // sampled at the falling edge so the sender and receiver updates have settled
    task automatic wait_idle();
        while (pending_slots.size() != 0 || in_ch.valid || columns_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_face_mode(input logic mode);
        cfg_ch.valid <= 1'b1;
        cfg_ch.face_mode <= mode;
        do @(posedge i_clk); while (!cfg_ch.ready);
        face_mode_now = mode;
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        logic modes[4];
        modes = '{FACE_TICKS, FACE_NUMERALS, FACE_TICKS, FACE_NUMERALS};
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.slot_count = '0;
        in_ch.hour_value = '0;
        in_ch.minute_value = '0;
        in_ch.second_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.face_mode = FACE_TICKS;
        res_ch.ready = 1'b0;
        held_col = pcfc_pkg::COLUMN_DARK;
        face_mode_now = FACE_TICKS;
        mismatches = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // first phase runs on the reset value of the face mode
        add_directed_slots();
        repeat (RAND_PER_PHASE / 2) add_random_slot();
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_face_mode(modes[ph]);
            if (ph < 2) add_directed_slots();
            repeat (RAND_PER_PHASE) add_random_slot();
        end
        wait_idle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pcfc_pkg.sv
rtl/core/pcfc_if.sv
rtl/core/pov_clock_face_column_top.sv
rtl/core/pcfc_checker.sv
verif/pov_clock_face_column_top_tb.sv
